// ===== design/ctp_pkg.sv =====
// shared types and codes for the countdown timer pool
package ctp_pkg;

   localparam int unsigned COUNT_W = 32;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned GRANT_W = 3;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_SET   = 3'd2,
      OP_QUERY = 3'd3,
      OP_CLEAR = 3'd4,
      OP_TICK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TS_IDLE    = 2'd0,
      TS_RUNNING = 2'd1,
      TS_FIRED   = 2'd2
   } tstate_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               accept;
      op_type             op;
      logic [COUNT_W-1:0] load;
   } cell_cmd_type;

   // state reported by each cell
   typedef struct packed {
      logic in_use;
      logic running;
      logic zero;
      logic grant;
   } cell_stat_type;

endpackage

// ===== design/ctp_cell.sv =====
// one timer slot: allocation flags, countdown register and allocate chain link
module ctp_cell
   import ctp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          sel,
   input  logic          alloc_pend_in,
   output logic          alloc_pend_out,
   output cell_stat_type stat
);

   logic               in_use_ff, in_use_in;
   logic               running_ff, running_in;
   logic [COUNT_W-1:0] remaining_ff, remaining_in;
   logic               grant;

   // allocate request passes on only while this slot and all lower slots are taken
   assign grant          = alloc_pend_in && !in_use_ff;
   assign alloc_pend_out = alloc_pend_in && in_use_ff;

   assign stat.in_use  = in_use_ff;
   assign stat.running = running_ff;
   assign stat.zero    = (remaining_ff == '0);
   assign stat.grant   = grant;

   always_comb begin
      in_use_in    = in_use_ff;
      running_in   = running_ff;
      remaining_in = remaining_ff;
      if (cmd.accept) begin
         unique case (cmd.op)
            OP_ALLOC: begin
               if (grant) begin
                  in_use_in  = 1'b1;
                  running_in = 1'b0;
               end
            end
            OP_FREE: begin
               if (sel) begin
                  in_use_in  = 1'b0;
                  running_in = 1'b0;
               end
            end
            OP_SET: begin
               if (sel && in_use_ff) begin
                  remaining_in = cmd.load;
                  running_in   = 1'b1;
               end
            end
            OP_CLEAR: begin
               if (sel && in_use_ff) begin
                  running_in = 1'b0;
               end
            end
            OP_TICK: begin
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - COUNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= 1'b0;
         running_ff   <= 1'b0;
         remaining_ff <= '0;
      end else begin
         in_use_ff    <= in_use_in;
         running_ff   <= running_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== design/countdown_timer_pool_top.sv =====
// countdown timer pool: row of slot cells, shared decode and registered result
//
//   channel  dir  handshake                   payload
//   req      in   req_tvalid / req_tready     tuser: op; tdata: slot, load_count
//   rsp      out  rsp_tvalid / rsp_tready     tdata: status, granted_slot,
//                                                    timer_state, tick_total
//
// one transaction per cycle while req_tready is high; its result appears in the output register on the next cycle
// the allocate priority chain through all NUM_TIMERS cells sets the longest path
// req_tready drops only while a result waits in the output register and rsp_tready is low
// synchronous reset frees every slot, stops all timers and zeroes the tick counter
module countdown_timer_pool_top
   import ctp_pkg::*;
#(
   parameter int unsigned NUM_TIMERS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] op
   input  logic [39:0] req_tdata,   // [7:0] slot, [39:8] load_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [4:2] granted_slot,
                                    // [6:5] timer_state, [38:7] tick_total, [39] zero
);

   logic                  accept;
   op_type                op;
   logic [SLOT_W-1:0]     slot;
   logic                  in_range;
   cell_cmd_type          cmd;
   logic [NUM_TIMERS-1:0] sel;
   logic [NUM_TIMERS:0]   pend;
   cell_stat_type         stat [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] grant_vec;
   logic [NUM_TIMERS-1:0] in_use_vec;

   logic                  q_in_use, q_running, q_zero;
   logic [GRANT_W-1:0]    granted;
   status_type            status;
   tstate_type            tstate;

   logic [COUNT_W-1:0]    tick_ff, tick_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]           rsp_tdata_ff, rsp_tdata_in;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign slot       = req_tdata[SLOT_W-1:0];
   assign in_range   = (slot < SLOT_W'(NUM_TIMERS));

   assign cmd.accept = accept;
   assign cmd.op     = op;
   assign cmd.load   = req_tdata[SLOT_W +: COUNT_W];

   assign pend[0] = 1'b1;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      assign sel[i]        = in_range && (slot == SLOT_W'(i));
      assign grant_vec[i]  = stat[i].grant;
      assign in_use_vec[i] = stat[i].in_use;

      ctp_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .sel            (sel[i]),
         .alloc_pend_in  (pend[i]),
         .alloc_pend_out (pend[i+1]),
         .stat           (stat[i])
      );
   end

   // selected slot flags and granted number, gathered over the row
   always_comb begin
      q_in_use  = 1'b0;
      q_running = 1'b0;
      q_zero    = 1'b0;
      granted   = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         q_in_use  = q_in_use  | (sel[i] & stat[i].in_use);
         q_running = q_running | (sel[i] & stat[i].running);
         q_zero    = q_zero    | (sel[i] & stat[i].zero);
         if (grant_vec[i]) begin
            granted = granted | GRANT_W'(i);
         end
      end
   end

   always_comb begin
      status  = ST_OK;
      tstate  = TS_IDLE;
      tick_in = tick_ff;
      unique case (op)
         OP_ALLOC: begin
            if (pend[NUM_TIMERS]) begin
               status = ST_FULL;
            end
         end
         OP_FREE: begin
            if (!in_range) begin
               status = ST_RANGE;
            end
         end
         OP_SET, OP_CLEAR: begin
            priority if (!in_range) begin
               status = ST_RANGE;
            end else if (!q_in_use) begin
               status = ST_NOT_ALLOC;
            end
         end
         OP_QUERY: begin
            priority if (!in_range) begin
               status = ST_RANGE;
            end else if (q_in_use && q_running) begin
               tstate = q_zero ? TS_FIRED : TS_RUNNING;
            end
         end
         OP_TICK: begin
            tick_in = tick_ff + COUNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, tick_in, tstate,
                          (op == OP_ALLOC && !pend[NUM_TIMERS]) ? granted : GRANT_W'(0),
                          status};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         tick_ff       <= '0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (accept) begin
            tick_ff <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_one_grant: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant_vec))
      else $error("more than one cell claims the allocate");

   a_full_all_used: assert property (@(posedge clock) disable iff (reset)
      pend[NUM_TIMERS] |-> (&in_use_vec))
      else $error("pool reported full with a free slot");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_TICK) |=> (tick_ff == $past(tick_ff) + COUNT_W'(1)))
      else $error("tick counter did not advance on tick");

   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && op != OP_TICK) |=> $stable(tick_ff))
      else $error("tick counter moved without a tick");

   a_tick_reported: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_tvalid && rsp_tdata[38:7] == tick_ff))
      else $error("result tick_total differs from tick counter");

endmodule
